[src/css_pkg.sv]
// Shared types, constants and arithmetic for the cross stencil smoothing block.
package css_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int CHANNELS      = 3;
  localparam int CHAN_W        = 8;
  localparam int PIX_W         = CHANNELS * CHAN_W;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int ROW_W         = 12;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int MIN_SIZE      = 3;
  localparam int RESET_WIDTH   = 800;
  localparam int RESET_HEIGHT  = 600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } css_reg_t;

  // Per-word position flags handed from the position tracker to the datapath.
  typedef struct packed {
    logic interior;
    logic frame_last;
  } css_flags_t;

  // (4*center + n + s + e + w) >> 3; the 11-bit sum cannot overflow.
  function automatic logic [CHAN_W-1:0] stencil(
    input logic [CHAN_W-1:0] ctr,
    input logic [CHAN_W-1:0] nth,
    input logic [CHAN_W-1:0] sth,
    input logic [CHAN_W-1:0] est,
    input logic [CHAN_W-1:0] wst
  );
    logic [CHAN_W+2:0] sum;
    sum = {1'b0, ctr, 2'b00} + {3'b000, nth} + {3'b000, sth}
        + {3'b000, est} + {3'b000, wst};
    return sum[CHAN_W+2:3];
  endfunction

endpackage

[src/css_if.sv]
// Stream interfaces for pixel words in and smoothed words out.
interface css_in_if
  import css_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_zero;
  logic [CHAN_W-1:0] chan_one;
  logic [CHAN_W-1:0] chan_two;

  modport source (output valid, output chan_zero, output chan_one, output chan_two,
                  input ready);
  modport sink   (input valid, input chan_zero, input chan_one, input chan_two,
                  output ready);
endinterface

interface css_out_if
  import css_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_zero;
  logic [CHAN_W-1:0] out_one;
  logic [CHAN_W-1:0] out_two;
  logic              frame_last;

  modport source (output valid, output out_zero, output out_one, output out_two,
                  output frame_last, input ready);
  modport sink   (input valid, input out_zero, input out_one, input out_two,
                  input frame_last, output ready);
endinterface

[src/cross_stencil_smoothing.sv]
// Top level of the five-point stencil smoothing block.
//
// Smooths a raster stream of 3 x 8-bit pixels with the kernel
// [0 1 0; 1 4 1; 0 1 0]/8 (rounded down) and emits one word per interior
// pixel, once that pixel's south neighbor has arrived; border pixels give no
// word and frame_last marks the final interior pixel of a frame. The block
// takes one pixel per clock unless the output stalls; results pass through
// the stage-1 and output registers. The east tap leaves the line memory the
// cycle after it is addressed. Both line buffers share one 48-bit wide RAM of
// MAX_WIDTH entries (north row in the upper half, row above in the lower),
// read once and written once per pixel. Line memory is not cleared; no start-
// up pass is needed, since rows are always written before they are read.
// A write to image_width or image_height restarts the frame at row 0,
// column 0; sizes outside [3, MAX_WIDTH] / [3, 4096] saturate. Write the
// configuration only while no pixel is in flight.
module cross_stencil_smoothing
  import css_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  css_in_if.sink               in_pix,
  css_out_if.source            out_pix
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic             in_acc;
  logic             s1_adv;
  logic [AW-1:0]    col;
  logic [AW-1:0]    pf_addr;
  css_flags_t       flags;
  logic [2*PIX_W-1:0] rd_word;
  logic [PIX_W-1:0] pix;
  logic [PIX_W-1:0] center;
  logic [PIX_W-1:0] east;

  // stage 1: taps captured at accept, east tap still in the RAM read register
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] s1_ctr_r;
  logic [PIX_W-1:0] s1_nth_r;
  logic [PIX_W-1:0] s1_wst_r;
  logic             s1_last_r;
  logic [PIX_W-1:0] west_r;

  // output register
  logic              out_v_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;
  logic [PIX_W-1:0]  res;

  assign s1_adv        = s1_v_r && (!out_v_r || out_pix.ready);
  assign in_pix.ready  = !s1_v_r || s1_adv;
  assign in_acc        = in_pix.valid && in_pix.ready;

  assign pix    = {in_pix.chan_two, in_pix.chan_one, in_pix.chan_zero};
  // prefetched entry for this column: upper half north, lower half center
  assign center = rd_word[PIX_W-1:0];
  assign east   = rd_word[PIX_W-1:0];

  css_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (in_acc),
    .col       (col),
    .pf_addr   (pf_addr),
    .flags     (flags)
  );

  // line buffers: center shifts into the north half, the new pixel into the lower
  css_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_acc),
    .waddr (col),
    .wdata ({center, pix}),
    .re    (in_acc),
    .raddr (pf_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      west_r  <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= flags.interior;
        west_r <= center;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= pix;
      s1_ctr_r  <= center;
      s1_nth_r  <= rd_word[2*PIX_W-1:PIX_W];
      s1_wst_r  <= west_r;
      s1_last_r <= flags.frame_last;
    end
    if (s1_adv) begin
      out_pix_r  <= res;
      out_last_r <= s1_last_r;
    end
  end

  // per-channel stencil; south is the pixel that just arrived
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      res[c*CHAN_W +: CHAN_W] = stencil(s1_ctr_r[c*CHAN_W +: CHAN_W],
                                        s1_nth_r[c*CHAN_W +: CHAN_W],
                                        s1_pix_r[c*CHAN_W +: CHAN_W],
                                        east[c*CHAN_W +: CHAN_W],
                                        s1_wst_r[c*CHAN_W +: CHAN_W]);
    end
  end

  assign out_pix.valid      = out_v_r;
  assign out_pix.out_zero   = out_pix_r[CHAN_W-1:0];
  assign out_pix.out_one    = out_pix_r[2*CHAN_W-1:CHAN_W];
  assign out_pix.out_two    = out_pix_r[3*CHAN_W-1:2*CHAN_W];
  assign out_pix.frame_last = out_last_r;

endmodule

[src/css_ram.sv]
// Generic single-clock RAM, one write port, one read port, registered read.
module css_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/css_pos.sv]
// Frame geometry registers and column/row tracking.
module css_pos
  import css_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         adv,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [$clog2(MAX_WIDTH)-1:0] pf_addr,
  output css_flags_t                   flags
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > CFG_W) ? WW : CFG_W;
  localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;

  logic [AW-1:0]    w_last_r, w_last_nxt;
  logic [ROW_W-1:0] h_last_r, h_last_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    cw_val;
  logic [CW-1:0]    cw_clamp;
  logic [CFG_W-1:0] ch_clamp;
  logic             row_end;

  // clamp written sizes into the supported range
  always_comb begin
    cw_val = CW'(cfg_wdata);
    priority if (cw_val < CW'(MIN_SIZE))  cw_clamp = CW'(MIN_SIZE);
    else if (cw_val > CW'(MAX_WIDTH))     cw_clamp = CW'(MAX_WIDTH);
    else                                  cw_clamp = cw_val;
    priority if (cfg_wdata < CFG_W'(MIN_SIZE))         ch_clamp = CFG_W'(MIN_SIZE);
    else if (cfg_wdata > CFG_W'(HEIGHT_LIMIT))         ch_clamp = CFG_W'(HEIGHT_LIMIT);
    else                                               ch_clamp = cfg_wdata;
  end

  assign row_end = (col_r == w_last_r);

  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_we) begin
      unique case (css_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  w_last_nxt = AW'(cw_clamp - CW'(1));
        REG_IMAGE_HEIGHT: h_last_nxt = ROW_W'(ch_clamp - CFG_W'(1));
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (adv) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= AW'(RST_W - 1);
      h_last_r <= ROW_W'(RESET_HEIGHT - 1);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  assign col     = col_r;
  // fetch the east tap; at row end fetch column 0 for the next row's center
  assign pf_addr = row_end ? '0 : col_r + AW'(1);

  assign flags.interior   = (row_r >= ROW_W'(2)) && (col_r != '0) && !row_end;
  assign flags.frame_last = (row_r == h_last_r) && (col_r == w_last_r - AW'(1));

endmodule

[verif/tb.sv]
// Self-checking testbench for the five-point stencil smoothing block.
module tb;
  import css_pkg::*;

  localparam int FLUSH_CYCLES  = 8;        // drain margin after the last expected word
  localparam int CYCLE_LIMIT   = 600_000;  // watchdog bound on the whole run
  localparam int RANDOM_PIXELS = 1000;

  // One expected output word: packed channels (channel c at bits 8c) plus the flag.
  typedef struct packed {
    logic             frame_last;
    logic [PIX_W-1:0] pix;
  } smoothed_t;

  // Tracks frame position and line buffers, predicts each smoothed word and
  // checks the words leaving the block in order.
  class blur_scoreboard;
    logic [PIX_W-1:0] row_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] row_two_above [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] west_tap;
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    smoothed_t        smoothed_q[$];
    int               mismatches;
    string            chan_names[CHANNELS];

    function new();
      foreach (row_above[i]) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      width_reg  = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      mismatches = 0;
      chan_names = '{"out_zero", "out_one", "out_two"};
      restart();
    endfunction

    function void restart();
      col      = 0;
      row      = 0;
      west_tap = '0;
    endfunction

    function int unsigned used_size(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    // Any register write restarts the frame; line buffers keep their contents.
    function void write_reg(css_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
      restart();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned      w;
      int unsigned      h;
      int unsigned      x;
      int unsigned      r;
      int unsigned      sum;
      logic [PIX_W-1:0] center;
      logic [PIX_W-1:0] east;
      logic [PIX_W-1:0] north;
      smoothed_t        word;
      w = used_size(width_reg, MAX_WIDTH_DEF);
      h = used_size(height_reg, HEIGHT_LIMIT);
      x = (col >= w) ? 0 : col;
      r = (row >= h) ? 0 : row;
      center = row_above[x];
      east   = (x + 1 < w) ? row_above[x + 1] : '0;
      north  = row_two_above[x];
      // the arriving pixel is the south neighbor of (r-1, x)
      if (r >= 2 && x >= 1 && x + 2 <= w) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sum = 4 * center[c*CHAN_W +: CHAN_W] + west_tap[c*CHAN_W +: CHAN_W]
              + east[c*CHAN_W +: CHAN_W] + north[c*CHAN_W +: CHAN_W]
              + pix[c*CHAN_W +: CHAN_W];
          word.pix[c*CHAN_W +: CHAN_W] = CHAN_W'(sum >> 3);
        end
        word.frame_last = (r + 1 == h && x + 2 == w);
        smoothed_q.push_back(word);
      end
      west_tap         = center;
      row_two_above[x] = center;
      row_above[x]     = pix;
      x++;
      if (x >= w) begin
        x = 0;
        r++;
        if (r >= h) r = 0;
      end
      col = x;
      row = r;
    endfunction

    function int unsigned pending();
      return smoothed_q.size();
    endfunction

    function void check_word(logic [PIX_W-1:0] pix, logic last);
      smoothed_t want;
      if (smoothed_q.size() == 0) begin
        $error("word with nothing expected: pix=%06h frame_last=%0d", pix, last);
        mismatches++;
        return;
      end
      want = smoothed_q.pop_front();
      for (int c = 0; c < CHANNELS; c++) begin
        if (pix[c*CHAN_W +: CHAN_W] !== want.pix[c*CHAN_W +: CHAN_W]) begin
          $error("%s: expected %0d, got %0d", chan_names[c],
                 want.pix[c*CHAN_W +: CHAN_W], pix[c*CHAN_W +: CHAN_W]);
          mismatches++;
        end
      end
      if (last !== want.frame_last) begin
        $error("frame_last: expected %0d, got %0d", want.frame_last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  css_in_if  in_pix();
  css_out_if out_pix();

  cross_stencil_smoothing dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_pix   (in_pix),
    .out_pix  (out_pix)
  );

  blur_scoreboard board;

  // stall percentages per side; calm counters give stretches without stalls
  int          send_idle_pct;
  int          recv_idle_pct;
  int          send_calm;
  int          recv_calm;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns 1 when this side should stall for the coming cycle.
  function automatic bit stall_roll(int pct, inout int calm);
    if (calm > 0) begin
      calm--;
      return 1'b0;
    end
    if ($urandom_range(49) == 0) begin
      calm = $urandom_range(20, 60);
      return 1'b0;
    end
    return $urandom_range(99) < pct;
  endfunction

  // Channel values lean on the extremes so the 11-bit sums hit both ends.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    out_pix.ready = !stall_roll(recv_idle_pct, recv_calm);
  end

  // Output monitor: values seen at the rising edge are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_pix.valid && out_pix.ready)
      board.check_word({out_pix.out_two, out_pix.out_one, out_pix.out_zero},
                       out_pix.frame_last);
  end

  // Watchdog: a hang or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one pixel word; valid stays high across back-to-back words.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (stall_roll(send_idle_pct, send_calm)) begin
      in_pix.valid = 1'b0;
      @(negedge clk);
    end
    in_pix.valid     = 1'b1;
    in_pix.chan_zero = pix[0*CHAN_W +: CHAN_W];
    in_pix.chan_one  = pix[1*CHAN_W +: CHAN_W];
    in_pix.chan_two  = pix[2*CHAN_W +: CHAN_W];
    do @(posedge clk); while (!in_pix.ready);
    board.note_pixel(pix);
  endtask

  task automatic hold_stream();
    @(negedge clk);
    in_pix.valid = 1'b0;
  endtask

  // Wait for every expected word, then let pixels that make no word drain too.
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input css_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // New frame geometry, then npix random pixels; pause_at >= 0 stops the sender
  // mid-stream until the output side has caught up.
  task automatic run_frames(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval,
                            input int unsigned npix, input int pause_at);
    hold_stream();
    settle();
    if ($urandom_range(1)) begin
      write_reg(REG_IMAGE_WIDTH, wval);
      write_reg(REG_IMAGE_HEIGHT, hval);
    end else begin
      write_reg(REG_IMAGE_HEIGHT, hval);
      write_reg(REG_IMAGE_WIDTH, wval);
    end
    for (int i = 0; i < npix; i++) begin
      if (i == pause_at) begin
        hold_stream();
        while (board.pending() != 0) @(posedge clk);
      end
      send_pixel({rand_chan(), rand_chan(), rand_chan()});
    end
  endtask

  initial begin
    logic [PIX_W-1:0] mixed_frame [9];
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] hval;
    int unsigned      frame_px;
    int unsigned      npix;
    int unsigned      sent;
    int               pause_at;
    bit               first;

    board = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_IMAGE_WIDTH;
    cfg_wdata        = '0;
    in_pix.valid     = 1'b0;
    in_pix.chan_zero = '0;
    in_pix.chan_one  = '0;
    in_pix.chan_two  = '0;
    out_pix.ready    = 1'b0;
    send_calm        = 0;
    recv_calm        = 0;
    cycle_count      = 0;
    send_idle_pct    = 20;
    recv_idle_pct    = 85;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A few pixels at the reset geometry (800x600), then a write cuts the frame
    // short: the counters must restart.
    for (int i = 0; i < 5; i++) send_pixel({rand_chan(), rand_chan(), rand_chan()});
    hold_stream();
    settle();
    // Both sizes below the minimum saturate to 3x3: one interior pixel per frame.
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
    // All-ones frame: largest possible sum, result 255 with frame_last.
    for (int i = 0; i < 9; i++) send_pixel('1);
    // Second frame right behind it checks the wrap; the bright center with dark
    // and mixed neighbors exercises each tap separately.
    mixed_frame = '{24'h000000, 24'h010204, 24'h000000,
                    24'h80AA55, 24'hFFFFFF, 24'h55AA80,
                    24'h000000, 24'h7F3F1F, 24'h000000};
    for (int i = 0; i < 9; i++) send_pixel(mixed_frame[i]);

    // Random geometry phases: mostly small frames, whole frames back to back,
    // sometimes a partial frame that the next write cuts off.
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_PIXELS) begin
      if (sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 85;
      end else if (sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: wval = CFG_W'($urandom_range(2));
        1: wval = CFG_W'($urandom_range(11, 40));
        default: wval = CFG_W'($urandom_range(3, 10));
      endcase
      hval = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(2))
                                      : CFG_W'($urandom_range(3, 8));
      frame_px = board.used_size(wval, MAX_WIDTH_DEF) * board.used_size(hval, HEIGHT_LIMIT);
      npix     = frame_px * $urandom_range(1, 2);
      if ($urandom_range(1)) npix += $urandom_range(frame_px - 1);
      pause_at = (first || $urandom_range(3) == 0) ? int'($urandom_range(npix - 1)) : -1;
      run_frames(wval, hval, npix, pause_at);
      sent += npix;
      first = 1'b0;
    end

    // Largest sizes, a short partial frame each with the other dimension at its
    // minimum: exact width bound, saturated width, saturated height.
    run_frames(CFG_W'(4096), CFG_W'(3), 64, -1);
    run_frames('1, CFG_W'(3), 64, -1);
    run_frames(CFG_W'(3), '1, 64, -1);

    hold_stream();
    settle();
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
